// ----- design/bda_pkg.sv -----
`timescale 1ns / 1ps
package bda_pkg;

  // Operation codes
  localparam logic [2:0] MODE_MUL = 3'd0;
  localparam logic [2:0] MODE_MAC = 3'd1;
  localparam logic [2:0] MODE_ADC = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_QFIX = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [31:0] operand_d;
    logic [31:0] operand_e;
    logic [31:0] operand_f;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_high;
    logic [31:0] result_low;
    logic        overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic mac;
    logic div;
    logic out_load;
  } bda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } bda_sts_t;

endpackage

// ----- design/bda_datapath.sv -----
`timescale 1ns / 1ps
module bda_datapath import bda_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  in_item_t  in_data,
  input  bda_cmd_t  cmd,
  output bda_sts_t  sts,
  output out_item_t out_data
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(3 * W + 1);

  logic [2:0]       mode_r;
  logic [W-1:0]     a_r, b_r, c_r, d_r;
  logic [2*W-1:0]   prod_r;
  logic [3*W-1:0]   shreg_r;
  logic [2*W-1:0]   rem_r;
  logic [2*W-1:0]   dvs_r;
  logic [CW-1:0]    cnt_r;
  out_item_t        out_r;

  logic [W-1:0]     in_a, in_b, in_c, in_d, in_e, in_f;
  logic [2*W:0]     trial;
  logic             ge;
  logic [W+1:0]     sum;
  logic [W-1:0]     q_fix;
  out_item_t        res;

  assign in_a = in_data.operand_a[W-1:0];
  assign in_b = in_data.operand_b[W-1:0];
  assign in_c = in_data.operand_c[W-1:0];
  assign in_d = in_data.operand_d[W-1:0];
  assign in_e = in_data.operand_e[W-1:0];
  assign in_f = in_data.operand_f[W-1:0];

  // Restoring divide: one dividend bit per step
  assign trial = {rem_r, shreg_r[3*W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  assign sts.div_done = (cnt_r == '0);

  // Load operands, then multiply, accumulate or divide on command, and register the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      a_r    <= in_a;
      b_r    <= in_b;
      c_r    <= in_c;
      d_r    <= in_d;
      if (in_data.mode == MODE_QFIX) begin
        rem_r   <= '0;
        shreg_r <= {in_d, in_e, in_f};
        dvs_r   <= {in_b, in_c};
        cnt_r   <= CW'(3 * W);
      end else begin
        rem_r   <= {{W{1'b0}}, in_a};
        shreg_r <= {in_b, {(2 * W){1'b0}}};
        dvs_r   <= {{W{1'b0}}, in_c};
        cnt_r   <= CW'(W);
      end
    end
    if (cmd.mul) begin
      prod_r <= a_r * b_r;
    end
    // Add carry and accumulator words only for multiply-accumulate
    if (cmd.mac && (mode_r == MODE_MAC)) begin
      prod_r <= prod_r + (2 * W)'(c_r) + (2 * W)'(d_r);
    end
    if (cmd.div) begin
      if (ge) begin
        rem_r <= trial[2*W-1:0] - dvs_r;
      end else begin
        rem_r <= trial[2*W-1:0];
      end
      shreg_r <= {shreg_r[3*W-2:0], ge};
      cnt_r   <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_r <= res;
    end
  end

  assign sum = (W + 2)'(a_r) + (W + 2)'(b_r) + (W + 2)'(c_r);

  // Clamp the full quotient to the given digit
  assign q_fix = ((|shreg_r[3*W-1:W]) || (shreg_r[W-1:0] > a_r)) ? a_r : shreg_r[W-1:0];

  // Select the result word pair for the mode
  always_comb begin
    res = '0;
    case (mode_r)
      MODE_MUL, MODE_MAC: begin
        res.result_high = 32'(prod_r[2*W-1:W]);
        res.result_low  = 32'(prod_r[W-1:0]);
      end
      MODE_ADC: begin
        res.result_high = 32'(sum[W+1:W]);
        res.result_low  = 32'(sum[W-1:0]);
      end
      MODE_DIV: begin
        if (a_r >= c_r) begin
          res.result_low = 32'({W{1'b1}});
          res.overflow   = 1'b1;
        end else begin
          res.result_high = 32'(rem_r[W-1:0]);
          res.result_low  = 32'(shreg_r[W-1:0]);
        end
      end
      MODE_QFIX: begin
        res.result_low = 32'(q_fix);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign out_data = out_r;

endmodule

// ----- design/bda_ctrl.sv -----
`timescale 1ns / 1ps
module bda_ctrl import bda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [2:0] in_mode,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  bda_sts_t sts,
  output bda_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one transaction through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_mode)
            MODE_MUL, MODE_MAC: state_nxt = ST_MUL;
            MODE_DIV, MODE_QFIX: state_nxt = ST_DIV;
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/bignum_digit_alu.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | in_item_t (mode, operand_a..f)
// out_    | output    | out_valid/out_stall | out_item_t (result_high/low, overflow)
//
// Add-with-carry and unused modes go straight to the finish state; multiply and
// multiply-accumulate pass the multiply and accumulate states; divide and quotient
// digit correction share the restoring divider, which retires one dividend bit a cycle.
// Reset (rst_n low, synchronous) returns the controller to idle, output empty.
// A finished result waits in the output register while the next transaction
// is taken; the block stalls the input from acceptance until its result is loaded.
module bignum_digit_alu import bda_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  bda_cmd_t cmd;
  bda_sts_t sts;

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bda_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- verif/bignum_digit_alu_test.sv -----
`timescale 1ns / 1ps
module bignum_digit_alu_test;
  import bda_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bignum_digit_alu u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        cycle_count = 0;
  bit        calm_phase = 1'b0;
  int        mode_seen[8];
  bit        accepted_q = 1'b0;
  int        out_stall_left = 0;

  // Compare q*(dh:dl) against the three-word value (u2:u1:u0)
  function automatic bit digit_fits(logic [63:0] q, logic [31:0] dh, logic [31:0] dl,
                                    logic [31:0] u2, logic [31:0] u1, logic [31:0] u0);
    logic [127:0] prod;
    logic [127:0] num;
    prod = q * {dh, dl};
    num = {32'd0, u2, u1, u0};
    return prod <= num;
  endfunction

  function automatic out_item_t alu_result(in_item_t it);
    out_item_t   r;
    logic [63:0] p;
    logic [63:0] lo_q, hi_q, mid;
    r = '0;
    case (it.mode)
      MODE_MUL: begin
        p = it.operand_a * it.operand_b;
        {r.result_high, r.result_low} = p;
      end
      MODE_MAC: begin
        p = 64'(it.operand_a) * 64'(it.operand_b) + 64'(it.operand_c) + 64'(it.operand_d);
        {r.result_high, r.result_low} = p;
      end
      MODE_ADC: begin
        p = 64'(it.operand_a) + 64'(it.operand_b) + 64'(it.operand_c);
        {r.result_high, r.result_low} = p;
      end
      MODE_DIV: begin
        if (it.operand_a >= it.operand_c) begin
          r.result_low = 32'hFFFF_FFFF;
          r.overflow = 1'b1;
        end else begin
          p = {it.operand_a, it.operand_b};
          r.result_low = 32'(p / it.operand_c);
          r.result_high = 32'(p % it.operand_c);
        end
      end
      MODE_QFIX: begin
        // binary search for the largest digit that still fits
        lo_q = 0;
        hi_q = it.operand_a;
        while (lo_q < hi_q) begin
          mid = lo_q + (hi_q - lo_q + 1) / 2;
          if (digit_fits(mid, it.operand_b, it.operand_c, it.operand_d, it.operand_e,
                         it.operand_f))
            lo_q = mid;
          else
            hi_q = mid - 1;
        end
        r.result_low = lo_q[31:0];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 15));
      3: return 32'h8000_0000 ^ 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(logic [2:0] m, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic [31:0] d, logic [31:0] e, logic [31:0] f);
    in_item_t it;
    it = '{m, a, b, c, d, e, f};
    pending_ops.push_back(it);
  endtask

  // Build a mode 4 case close to a real long-division step
  task automatic queue_digit_fix();
    logic [31:0]  dh, dl, q;
    logic [127:0] u;
    dh = $urandom() | 32'h8000_0000;
    dl = $urandom();
    if ($urandom_range(0, 7) == 0) dh = rand_word();
    q = $urandom();
    u = 128'(q) * {dh, dl};
    if ($urandom_range(0, 1)) u = u - 128'($urandom_range(0, 3));
    else u = u + 128'($urandom());
    queue_op(MODE_QFIX, q + 32'($urandom_range(0, 2)), dh, dl, u[95:64], u[63:32],
             u[31:0]);
  endtask

  initial begin
    logic [2:0] m;
    // directed corners
    queue_op(MODE_MUL, '1, '1, 0, 0, 0, 0);
    queue_op(MODE_MUL, 0, '1, 5, 5, 5, 5);
    queue_op(MODE_MAC, '1, '1, '1, '1, 0, 0);
    queue_op(MODE_MAC, 0, 0, 0, 0, '1, '1);
    queue_op(MODE_ADC, '1, '1, '1, 0, 0, 0);
    queue_op(MODE_ADC, '1, 1, 0, 0, 0, 0);
    queue_op(MODE_ADC, 0, 0, 0, 0, 0, 0);
    queue_op(MODE_DIV, 5, 7, 0, 0, 0, 0);
    queue_op(MODE_DIV, 0, 0, 0, 0, 0, 0);
    queue_op(MODE_DIV, 7, 1, 7, 0, 0, 0);
    queue_op(MODE_DIV, 32'hFFFF_FFFE, '1, '1, 0, 0, 0);
    queue_op(MODE_DIV, 0, '1, 1, 0, 0, 0);
    queue_op(MODE_DIV, 3, 32'h1234_5678, 32'h8000_0000, 0, 0, 0);
    queue_op(MODE_QFIX, '1, 0, 0, 0, 0, 0);
    queue_op(MODE_QFIX, '1, '1, '1, '1, '1, '1);
    queue_op(MODE_QFIX, '1, 32'h8000_0000, 0, 0, 0, 0);
    queue_op(MODE_QFIX, 0, 1, 1, 0, 0, 0);
    queue_op(MODE_QFIX, '1, 32'h8000_0000, 1, 32'h7FFF_FFFF, '1, '1);
    queue_op(3'd5, '1, '1, '1, '1, '1, '1);
    queue_op(3'd6, 1, 2, 3, 4, 5, 6);
    queue_op(3'd7, '1, 0, '1, 0, '1, 0);
    // random part
    for (int i = 0; i < 930; i++) begin
      m = 3'($urandom_range(0, 7));
      if (m > 4 && $urandom_range(0, 3) != 0) m = 3'($urandom_range(0, 4));
      if (m == MODE_QFIX && $urandom_range(0, 3) != 0) queue_digit_fix();
      else if (m == MODE_DIV && $urandom_range(0, 2) != 0)
        queue_op(m, $urandom(), $urandom(), $urandom() | 32'h8000_0000, $urandom(),
                 $urandom(), $urandom());
      else
        queue_op(m, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word());
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Driver: offer transactions at the falling edge, idle in short bursts
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_q) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm_phase <= pending_ops.size() < 120;
      // receiver stall bursts
      if (calm_phase) out_stall <= 1'b0;
      else if (out_stall_left > 0) out_stall_left <= out_stall_left - 1;
      else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        out_stall_left <= $urandom_range(0, 6);
      end else out_stall <= 1'b0;
    end
  end

  // Monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    out_item_t exp_r;
    accepted_q <= 1'b0;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(alu_result(in_data));
      mode_seen[in_data.mode]++;
      n_sent++;
      accepted_q <= 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.result_high !== exp_r.result_high) begin
          $error("result_high expected %h got %h", exp_r.result_high, out_data.result_high);
          n_errors++;
        end
        if (out_data.result_low !== exp_r.result_low) begin
          $error("result_low expected %h got %h", exp_r.result_low, out_data.result_low);
          n_errors++;
        end
        if (out_data.overflow !== exp_r.overflow) begin
          $error("overflow expected %b got %b", exp_r.overflow, out_data.overflow);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  // End of run: drain, settle, report
  initial begin
    wait (rst_n);
    wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (120) @(posedge clk);
    $display("Checked %0d of %0d transactions; per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_checked, n_sent, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
             mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog: a limit well above the slowest run
  initial begin
    wait (cycle_count >= 400000);
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/bda_pkg.sv
design/bda_datapath.sv
design/bda_ctrl.sv
design/bignum_digit_alu.sv
verif/bignum_digit_alu_test.sv
